@@ design/ess_pkg.sv @@
package ess_pkg;

  localparam logic [7:0] ESC = 8'h1B;

  // op queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    TK_BYTE,  // byte still subject to query matching
    TK_BYP,   // byte of an attached chunk, goes straight out
    TK_END    // end of one input beat
  } tok_kind_t;

  // front -> back
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic       att;
    logic       chunk_end;
  } op_t;

  // attributes stage -> cursor stage
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic       chunk_end;
    logic       attr_seen;
  } tok_t;

  // ESC [ ? 9 0 0 1 h
  function automatic logic [7:0] mode_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = ESC;
      3'd1:    c = 8'h5B;
      3'd2:    c = 8'h3F;
      3'd3:    c = 8'h39;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h30;
      3'd6:    c = 8'h31;
      default: c = 8'h68;
    endcase
    return c;
  endfunction

  // ESC [ c
  function automatic logic [7:0] attr_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0:    c = ESC;
      2'd1:    c = 8'h5B;
      default: c = 8'h63;
    endcase
    return c;
  endfunction

  // ESC [ 6 n
  function automatic logic [7:0] cursor_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0:    c = ESC;
      2'd1:    c = 8'h5B;
      2'd2:    c = 8'h36;
      default: c = 8'h6E;
    endcase
    return c;
  endfunction

endpackage

@@ design/ess_front.sv @@
module ess_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data,
  input  logic          in_attached,
  input  logic          in_chunk_end,
  output logic          op_valid,
  input  logic          op_ready,
  output ess_pkg::op_t  op
);

  logic [2:0] mode_progress;
  logic       attached_latch;
  logic       mid_chunk;

  // release job: prefix bytes, then the byte itself, then an end marker
  logic [2:0] pfx;
  logic [2:0] idx;
  logic       byte_en;
  logic       end_pend;
  logic [7:0] cur_byte;
  logic       cur_chunk_end;

  logic busy;
  logic in_pfx;
  logic accept;
  logic hit;
  logic att_now;

  assign in_pfx   = idx < pfx;
  assign busy     = in_pfx | byte_en | end_pend;
  assign in_ready = !busy || (op_ready && !in_pfx && !byte_en);
  assign accept   = in_valid && in_ready;
  assign hit      = in_data == ess_pkg::mode_char(mode_progress);
  assign att_now  = mid_chunk ? attached_latch : in_attached;

  assign op_valid = busy;

  always_comb begin
    op.att       = attached_latch;
    op.chunk_end = cur_chunk_end;
    if (in_pfx) begin
      op.kind = ess_pkg::TK_BYTE;
      op.data = ess_pkg::mode_char(idx);
    end else if (byte_en) begin
      op.kind = ess_pkg::TK_BYTE;
      op.data = cur_byte;
    end else begin
      op.kind = ess_pkg::TK_END;
      op.data = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_progress  <= 3'd0;
      attached_latch <= 1'b0;
      mid_chunk      <= 1'b0;
      pfx            <= 3'd0;
      idx            <= 3'd0;
      byte_en        <= 1'b0;
      end_pend       <= 1'b0;
    end else begin
      if (op_valid && op_ready) begin
        if (in_pfx) begin
          idx <= idx + 3'd1;
        end else if (byte_en) begin
          byte_en <= 1'b0;
        end else begin
          end_pend <= 1'b0;
        end
      end
      if (accept) begin
        attached_latch <= att_now;
        mid_chunk      <= !in_chunk_end;
        idx            <= 3'd0;
        end_pend       <= 1'b1;
        if (hit) begin
          // a full match wraps to zero and the sequence is dropped
          mode_progress <= (mode_progress == 3'd7) ? 3'd0 : mode_progress + 3'd1;
          pfx           <= 3'd0;
          byte_en       <= 1'b0;
        end else begin
          pfx           <= mode_progress;
          byte_en       <= in_data != ess_pkg::ESC;
          mode_progress <= (in_data == ess_pkg::ESC) ? 3'd1 : 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte      <= in_data;
      cur_chunk_end <= in_chunk_end;
    end
  end

endmodule

@@ design/ess_fifo.sv @@
module ess_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ess_pkg::op_t  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ess_pkg::op_t  pop_data
);

  ess_pkg::op_t mem [ess_pkg::QDEPTH];

  logic [ess_pkg::QAW-1:0] wr_ptr;
  logic [ess_pkg::QAW-1:0] rd_ptr;
  logic [ess_pkg::QCW-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = count != ess_pkg::QCW'(ess_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ess_pkg::QAW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= ess_pkg::QAW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/ess_back.sv @@
module ess_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  ess_pkg::op_t  op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          reply_attributes,
  output logic          reply_cursor,
  output logic          run_last
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       ra;
    logic       rc;
  } res_t;

  // ---------------- attributes stage ----------------
  logic [1:0]    attr_progress;
  logic          attr_seen;
  logic [1:0]    a_pfx;
  logic [1:0]    a_idx;
  logic          a_tail_en;
  ess_pkg::tok_t a_tail;

  logic          a_in_pfx;
  logic          a_busy;
  logic          a_emit;
  logic          a_last;
  logic          a_pop;
  logic          a_hit;
  ess_pkg::tok_t a_tok;

  // token register between the two matchers
  logic          mid_valid;
  ess_pkg::tok_t mid;
  logic          mid_pop;

  assign a_in_pfx = a_idx < a_pfx;
  assign a_busy   = a_in_pfx | a_tail_en;
  assign a_emit   = a_busy && (!mid_valid || mid_pop);
  assign a_last   = a_emit && (a_tail_en ? !a_in_pfx : (3'(a_idx) + 3'd1 == 3'(a_pfx)));
  assign op_ready = !a_busy || a_last;
  assign a_pop    = op_valid && op_ready;
  assign a_hit    = op.data == ess_pkg::attr_char(attr_progress);

  always_comb begin
    if (a_in_pfx) begin
      a_tok.kind      = ess_pkg::TK_BYTE;
      a_tok.data      = ess_pkg::attr_char(a_idx);
      a_tok.chunk_end = 1'b0;
      a_tok.attr_seen = 1'b0;
    end else begin
      a_tok = a_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_progress <= 2'd0;
      attr_seen     <= 1'b0;
      a_pfx         <= 2'd0;
      a_idx         <= 2'd0;
      a_tail_en     <= 1'b0;
    end else begin
      if (a_emit) begin
        if (a_in_pfx) begin
          a_idx <= a_idx + 2'd1;
        end else begin
          a_tail_en <= 1'b0;
        end
      end
      if (a_pop) begin
        a_idx <= 2'd0;
        case (op.kind)
          ess_pkg::TK_END: begin
            a_tail_en <= 1'b1;
            if (op.chunk_end) begin
              // partial query goes on unchanged
              a_pfx         <= attr_progress;
              attr_progress <= 2'd0;
              attr_seen     <= 1'b0;
            end else begin
              a_pfx <= 2'd0;
            end
          end
          default: begin
            if (op.att) begin
              a_pfx     <= 2'd0;
              a_tail_en <= 1'b1;
            end else if (a_hit) begin
              a_pfx     <= 2'd0;
              a_tail_en <= 1'b0;
              if (attr_progress == 2'd2) begin
                attr_progress <= 2'd0;
                attr_seen     <= 1'b1;
              end else begin
                attr_progress <= attr_progress + 2'd1;
              end
            end else begin
              a_pfx         <= attr_progress;
              a_tail_en     <= op.data != ess_pkg::ESC;
              attr_progress <= (op.data == ess_pkg::ESC) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_pop) begin
      a_tail.data      <= op.data;
      a_tail.chunk_end <= op.chunk_end;
      a_tail.attr_seen <= attr_seen && op.chunk_end;
      if (op.kind == ess_pkg::TK_END) begin
        a_tail.kind <= ess_pkg::TK_END;
      end else if (op.att) begin
        a_tail.kind <= ess_pkg::TK_BYP;
      end else begin
        a_tail.kind <= ess_pkg::TK_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (a_emit) begin
      mid_valid <= 1'b1;
    end else if (mid_pop) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_emit) begin
      mid <= a_tok;
    end
  end

  // ---------------- cursor stage ----------------
  logic [1:0] cursor_progress;
  logic       cursor_seen;
  logic [1:0] c_pfx;
  logic [1:0] c_idx;
  logic       c_byte_en;
  logic [7:0] c_byte;
  logic       c_flag_en;
  logic       c_ra;
  logic       c_rc;
  logic       c_done_en;

  logic       c_in_pfx;
  logic       c_busy;
  logic [2:0] c_rem;
  logic       step_ok;
  logic       c_step;
  logic       c_last;
  logic       c_hit;

  logic       hold_valid;
  res_t       hold;
  logic       res_en;
  res_t       res;
  logic       done_ev;

  assign c_in_pfx = c_idx < c_pfx;
  assign c_busy   = c_in_pfx | c_byte_en | c_flag_en | c_done_en;
  assign c_rem    = (c_in_pfx ? 3'(c_pfx - c_idx) : 3'd0) + 3'(c_byte_en) + 3'(c_flag_en)
                    + 3'(c_done_en);
  assign step_ok  = !hold_valid || !out_valid || out_ready;
  assign c_step   = c_busy && step_ok;
  assign c_last   = c_step && (c_rem == 3'd1);
  assign mid_pop  = mid_valid && (!c_busy || c_last);
  assign c_hit    = mid.data == ess_pkg::cursor_char(cursor_progress);

  always_comb begin
    res_en  = 1'b0;
    done_ev = 1'b0;
    res     = '0;
    if (c_step) begin
      if (c_in_pfx) begin
        res_en     = 1'b1;
        res.data   = ess_pkg::cursor_char(c_idx);
        res.valid  = 1'b1;
      end else if (c_byte_en) begin
        res_en     = 1'b1;
        res.data   = c_byte;
        res.valid  = 1'b1;
      end else if (c_flag_en) begin
        res_en     = 1'b1;
        res.ra     = c_ra;
        res.rc     = c_rc;
      end else begin
        done_ev    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_progress <= 2'd0;
      cursor_seen     <= 1'b0;
      c_pfx           <= 2'd0;
      c_idx           <= 2'd0;
      c_byte_en       <= 1'b0;
      c_flag_en       <= 1'b0;
      c_done_en       <= 1'b0;
    end else begin
      if (c_step) begin
        if (c_in_pfx) begin
          c_idx <= c_idx + 2'd1;
        end else if (c_byte_en) begin
          c_byte_en <= 1'b0;
        end else if (c_flag_en) begin
          c_flag_en <= 1'b0;
        end else begin
          c_done_en <= 1'b0;
        end
      end
      if (mid_pop) begin
        c_idx     <= 2'd0;
        c_pfx     <= 2'd0;
        c_byte_en <= 1'b0;
        c_flag_en <= 1'b0;
        c_done_en <= 1'b0;
        case (mid.kind)
          ess_pkg::TK_BYP: begin
            c_byte_en <= 1'b1;
          end
          ess_pkg::TK_END: begin
            c_done_en <= 1'b1;
            if (mid.chunk_end) begin
              c_pfx           <= cursor_progress;
              cursor_progress <= 2'd0;
              c_flag_en       <= mid.attr_seen | cursor_seen;
              cursor_seen     <= 1'b0;
            end
          end
          default: begin
            if (c_hit) begin
              if (cursor_progress == 2'd3) begin
                cursor_progress <= 2'd0;
                cursor_seen     <= 1'b1;
              end else begin
                cursor_progress <= cursor_progress + 2'd1;
              end
            end else begin
              c_pfx           <= cursor_progress;
              c_byte_en       <= mid.data != ess_pkg::ESC;
              cursor_progress <= (mid.data == ess_pkg::ESC) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      c_byte <= mid.data;
      c_ra   <= mid.attr_seen;
      c_rc   <= cursor_seen;
    end
  end

  // ---------------- output ----------------
  // one result is held back until the next one, or the end of the beat,
  // shows whether it is the last of its input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (res_en) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
        hold_valid <= 1'b1;
      end else if (done_ev && hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      hold <= res;
    end
    if ((res_en || done_ev) && hold_valid) begin
      out_byte         <= hold.data;
      byte_valid       <= hold.valid;
      reply_attributes <= hold.ra;
      reply_cursor     <= hold.rc;
      run_last         <= done_ev;
    end
  end

endmodule

@@ design/escape_sequence_stripper.sv @@
// Strips ESC[?9001h from a terminal byte stream, and while no client is
// attached also ESC[c and ESC[6n, flagging the replies owed at chunk end.
// A front stage runs the mode matcher and turns each input beat into byte
// ops plus one end marker; a four-entry op queue feeds a back stage where
// the attributes and cursor matchers run in cascade and results are
// registered. In the front an input beat issues a byte op and then an end
// marker when its byte is passed on, and only the end marker when its byte
// is held or deleted, with the bytes of a held mode prefix released on a
// mismatch issued as byte ops ahead of them. The back takes one op per
// cycle while the output is not stalled and no released query byte or
// reply flag result is being issued. Output m_axis_tlast marks the last
// result of an input beat; a beat that releases no bytes and flags
// nothing yields no output beat.
module escape_sequence_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] client_attached
  input  logic       s_axis_tlast,   // chunk_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] reply_attributes, [2] reply_cursor
  output logic       m_axis_tlast    // run_last
);

  logic         f_valid;
  logic         f_ready;
  ess_pkg::op_t f_op;
  logic         q_valid;
  logic         q_ready;
  ess_pkg::op_t q_op;

  ess_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata),
    .in_attached  (s_axis_tuser),
    .in_chunk_end (s_axis_tlast),
    .op_valid     (f_valid),
    .op_ready     (f_ready),
    .op           (f_op)
  );

  ess_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  ess_back u_back (
    .clk              (clk),
    .rst              (rst),
    .op_valid         (q_valid),
    .op_ready         (q_ready),
    .op               (q_op),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_byte         (m_axis_tdata),
    .byte_valid       (m_axis_tuser[0]),
    .reply_attributes (m_axis_tuser[1]),
    .reply_cursor     (m_axis_tuser[2]),
    .run_last         (m_axis_tlast)
  );

endmodule

@@ test/ess_checker.sv @@
`timescale 1ns / 100ps
module ess_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] client_attached
  input  logic       s_axis_tlast,   // chunk_end
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] reply_attributes, [2] reply_cursor
  input  logic       m_axis_tlast,   // run_last
  output int         mismatches,
  output int         outstanding
);

  localparam int MAX_RESULTS = 16;
  localparam int MAX_REPORTS = 10;
  localparam int MODE_LEN    = 8;
  localparam int ATTR_LEN    = 3;
  localparam int CURSOR_LEN  = 4;
  // first character in the low byte
  localparam logic [63:0] MODE_SEQ =
    {8'h68, 8'h31, 8'h30, 8'h30, 8'h39, 8'h3F, 8'h5B, ess_pkg::ESC};
  localparam logic [63:0] ATTR_SEQ   = {40'h0, 8'h63, 8'h5B, ess_pkg::ESC};
  localparam logic [63:0] CURSOR_SEQ = {32'h0, 8'h6E, 8'h36, 8'h5B, ess_pkg::ESC};

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       reply_attr;
    logic       reply_cursor;
    logic       last;
  } result_t;

  // outcome of feeding one byte to a matcher
  typedef struct packed {
    logic [3:0]  count;
    logic [63:0] bytes;
    logic        hit;
    logic [2:0]  prog;
  } match_t;

  logic [2:0] mode_prog;
  logic [2:0] attr_prog;
  logic [2:0] cursor_prog;
  logic       attr_seen;
  logic       cursor_seen;
  logic       attached;
  logic       mid_chunk;
  result_t    step_results[$];
  result_t    expected_results[$];
  int         results_checked;

  function automatic match_t match_byte(input logic [63:0] seq, input int len,
                                        input logic [2:0] prog, input logic [7:0] b);
    match_t      m;
    logic [63:0] held;
    int          p;
    int          n;
    int          i;
    m    = '0;
    held = '0;
    n    = 0;
    p    = int'(prog);
    if (p >= len) p = 0;
    if (b == seq[8*p +: 8]) begin
      p++;
      if (p == len) begin
        p     = 0;
        m.hit = 1'b1;
      end
    end else begin
      // mismatch gives back the held prefix; an ESC restarts the match
      for (i = 0; i < p; i++) begin
        held[8*n +: 8] = seq[8*i +: 8];
        n++;
      end
      if (b == ess_pkg::ESC) begin
        p = 1;
      end else begin
        held[8*n +: 8] = b;
        n++;
        p = 0;
      end
    end
    m.count = 4'(n);
    m.bytes = held;
    m.prog  = 3'(p);
    return m;
  endfunction

  task automatic add_result(input logic [7:0] data, input logic valid,
                            input logic ra, input logic rc);
    result_t r;
    r.data         = data;
    r.byte_valid   = valid;
    r.reply_attr   = ra;
    r.reply_cursor = rc;
    r.last         = 1'b0;
    if (step_results.size() < MAX_RESULTS) step_results.insert(step_results.size(), r);
  endtask

  task automatic cursor_stage(input logic [7:0] b);
    match_t m;
    int     i;
    m           = match_byte(CURSOR_SEQ, CURSOR_LEN, cursor_prog, b);
    cursor_prog = m.prog;
    if (m.hit) cursor_seen = 1'b1;
    for (i = 0; i < m.count; i++) add_result(m.bytes[8*i +: 8], 1'b1, 1'b0, 1'b0);
  endtask

  task automatic attr_stage(input logic [7:0] b);
    match_t m;
    int     i;
    if (attached) begin
      add_result(b, 1'b1, 1'b0, 1'b0);
    end else begin
      m         = match_byte(ATTR_SEQ, ATTR_LEN, attr_prog, b);
      attr_prog = m.prog;
      if (m.hit) attr_seen = 1'b1;
      for (i = 0; i < m.count; i++) cursor_stage(m.bytes[8*i +: 8]);
    end
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic client, input logic chunk_end);
    match_t m;
    int     i;
    int     p;
    step_results.delete();
    if (!mid_chunk) begin
      attached  = client;
      mid_chunk = 1'b1;
    end
    m         = match_byte(MODE_SEQ, MODE_LEN, mode_prog, b);
    mode_prog = m.prog;
    for (i = 0; i < m.count; i++) attr_stage(m.bytes[8*i +: 8]);
    if (chunk_end) begin
      // partial queries go out unchanged; a held mode prefix stays held
      p         = (attr_prog < ATTR_LEN) ? int'(attr_prog) : 0;
      attr_prog = '0;
      for (i = 0; i < p; i++) cursor_stage(ATTR_SEQ[8*i +: 8]);
      p           = (cursor_prog < CURSOR_LEN) ? int'(cursor_prog) : 0;
      cursor_prog = '0;
      for (i = 0; i < p; i++) add_result(CURSOR_SEQ[8*i +: 8], 1'b1, 1'b0, 1'b0);
      if (attr_seen || cursor_seen) add_result(8'h00, 1'b0, attr_seen, cursor_seen);
      attr_seen   = 1'b0;
      cursor_seen = 1'b0;
      mid_chunk   = 1'b0;
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i])
      expected_results.insert(expected_results.size(), step_results[i]);
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      mode_prog       = '0;
      attr_prog       = '0;
      cursor_prog     = '0;
      attr_seen       = 1'b0;
      cursor_seen     = 1'b0;
      attached        = 1'b0;
      mid_chunk       = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2], m_axis_tlast};
        if (expected_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result beat %0d unexpected: data %02h valid %b attr %b cursor %b last %b",
                     $realtime, results_checked, got.data, got.byte_valid, got.reply_attr,
                     got.reply_cursor, got.last);
          mismatches++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: result beat %0d mismatch", $realtime, results_checked);
              $display("  expected data %02h valid %b attr %b cursor %b last %b",
                       want.data, want.byte_valid, want.reply_attr, want.reply_cursor, want.last);
              $display("  actual   data %02h valid %b attr %b cursor %b last %b",
                       got.data, got.byte_valid, got.reply_attr, got.reply_cursor, got.last);
            end
            mismatches++;
          end
        end
        results_checked++;
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ test/tb_escape_sequence_stripper.sv @@
`timescale 1ns / 100ps
module tb_escape_sequence_stripper;

  localparam int TOTAL_BYTES  = 420;
  localparam int IDLE_PCT     = 36;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MODE_LEN     = 8;
  localparam int ATTR_LEN     = 3;
  localparam int CURSOR_LEN   = 4;
  localparam logic [63:0] MODE_SEQ =
    {8'h68, 8'h31, 8'h30, 8'h30, 8'h39, 8'h3F, 8'h5B, ess_pkg::ESC};
  localparam logic [63:0] ATTR_SEQ   = {40'h0, 8'h63, 8'h5B, ess_pkg::ESC};
  localparam logic [63:0] CURSOR_SEQ = {32'h0, 8'h6E, 8'h36, 8'h5B, ess_pkg::ESC};

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic       s_axis_tuser  = 1'b0;   // [0] client_attached
  logic       s_axis_tlast  = 1'b0;   // chunk_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [2:0] m_axis_tuser;           // [0] byte_valid, [1] reply_attributes, [2] reply_cursor
  logic       m_axis_tlast;           // run_last
  logic       calm          = 1'b0;

  int         mismatches;
  int         outstanding;
  int         quiet_cycles  = 0;
  int         bytes_sent    = 0;
  int         chunks_sent   = 0;
  int         attached_chunks = 0;
  int         results_seen  = 0;
  int         replies_seen  = 0;
  logic [7:0] chunk_bytes[$];

  escape_sequence_stripper dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ess_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[1] || m_axis_tuser[2]) replies_seen++;
    end
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding", quiet_cycles, outstanding);
      $display("tb_escape_sequence_stripper: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic client, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= client;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // client flag only counts on the first byte; later bytes get noise there
  task automatic send_chunk(input logic client);
    int n;
    int i;
    n = chunk_bytes.size();
    for (i = 0; i < n; i++)
      send_beat(chunk_bytes[i], (i == 0) ? client : 1'($urandom_range(1)), i == n - 1);
    chunks_sent++;
    if (client) attached_chunks++;
    chunk_bytes.delete();
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic append_byte(input logic [7:0] b);
    chunk_bytes.insert(chunk_bytes.size(), b);
  endtask

  task automatic add_seq(input logic [63:0] seq, input int len);
    int i;
    for (i = 0; i < len; i++) append_byte(seq[8*i +: 8]);
  endtask

  function automatic logic [7:0] near_byte();
    logic [7:0] b;
    case ($urandom_range(9)) inside
      0, 1:    b = ess_pkg::ESC;
      2:       b = 8'h5B;
      3:       b = 8'h3F;
      4:       b = 8'h36;
      5:       b = 8'h63;
      6:       b = 8'h6E;
      7:       b = 8'h30;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic add_fragment();
    logic [63:0] seq;
    int          len;
    int          kind;
    int          pos;
    case ($urandom_range(2))
      0: begin
        seq = MODE_SEQ;
        len = MODE_LEN;
      end
      1: begin
        seq = ATTR_SEQ;
        len = ATTR_LEN;
      end
      default: begin
        seq = CURSOR_SEQ;
        len = CURSOR_LEN;
      end
    endcase
    kind = $urandom_range(99);
    if (kind < 20) begin
      add_seq(MODE_SEQ, MODE_LEN);
    end else if (kind < 35) begin
      add_seq(ATTR_SEQ, ATTR_LEN);
    end else if (kind < 50) begin
      add_seq(CURSOR_SEQ, CURSOR_LEN);
    end else if (kind < 62) begin
      add_seq(seq, $urandom_range(len - 1, 1));
    end else if (kind < 72) begin
      pos = chunk_bytes.size() + $urandom_range(len - 1);
      add_seq(seq, len);
      chunk_bytes[pos] = near_byte();
    end else if (kind < 78) begin
      // query split by a deleted mode sequence
      if (len == MODE_LEN) begin
        seq = CURSOR_SEQ;
        len = CURSOR_LEN;
      end
      add_seq(seq, len - 1);
      add_seq(MODE_SEQ, MODE_LEN);
      append_byte(seq[8*(len - 1) +: 8]);
    end else if (kind < 90) begin
      repeat ($urandom_range(3, 1)) append_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 1)) append_byte(near_byte());
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // extremes plus both queries in a detached chunk
    append_byte(8'h00);
    append_byte(8'hFF);
    add_seq(ATTR_SEQ, ATTR_LEN);
    add_seq(CURSOR_SEQ, CURSOR_LEN);
    send_chunk(1'b0);
    // attached chunk passes the query through
    add_seq(ATTR_SEQ, ATTR_LEN);
    send_chunk(1'b1);
    // mode prefix held over the chunk end, completed in an attached chunk
    add_seq(MODE_SEQ, 5);
    send_chunk(1'b0);
    append_byte(8'h30);
    append_byte(8'h31);
    append_byte(8'h68);
    append_byte(8'h41);
    send_chunk(1'b1);
    // partial cursor query flushed at chunk end
    add_seq(CURSOR_SEQ, 3);
    send_chunk(1'b0);

    while (bytes_sent < TOTAL_BYTES) begin
      if (!paused && bytes_sent >= 200) begin
        paused = 1'b1;
        wait_for_results();
      end
      calm <= (bytes_sent >= 260 && bytes_sent < 360);
      repeat ($urandom_range(3, 1)) add_fragment();
      send_chunk($urandom_range(99) < 30);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d chunks, %0d of them with a client attached",
             bytes_sent, chunks_sent, attached_chunks);
    $display("checked %0d result beats, %0d carrying reply requests, %0d mismatches",
             results_seen, replies_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_escape_sequence_stripper: PASS");
    end else begin
      $display("tb_escape_sequence_stripper: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ess_pkg.sv
design/ess_front.sv
design/ess_fifo.sv
design/ess_back.sv
design/escape_sequence_stripper.sv
test/ess_checker.sv
test/tb_escape_sequence_stripper.sv
